// ----- rtl/core/swvm_pkg.sv -----
`default_nettype none

package swvm_pkg;

   localparam int LEVEL_W   = 21;
   localparam int DECAY_W   = 16;
   localparam int PHASE_W   = 32;
   localparam int SAMPLE_W  = 16;
   localparam int KEY_W     = 5;
   localparam int CSR_IDX_W = 2;
   localparam int AMP_SHIFT = 8;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 21'd2097151;
   localparam logic [LEVEL_W-1:0] PEAK_RESET  = 21'd1845494;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd461;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP = 2'd1;

   // item kinds carried in tuser
   localparam logic OP_CONTROL = 1'b0;
   localparam logic OP_SAMPLE  = 1'b1;

   // 220 * 2^(n/12) Hz in Q16
   localparam logic [31:0] SEMITONE_Q16 [12] = '{
      32'd14417920, 32'd15275254, 32'd16183568, 32'd17145893,
      32'd18165441, 32'd19245614, 32'd20390018, 32'd21602472,
      32'd22887021, 32'd24247955, 32'd25689813, 32'd27217409
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/square_wave_voice_mixer.sv -----
// Square-wave voice mixer. Each item on the req channel is either a control
// tick (tuser = 0), which may press one key, or a sample request (tuser = 1),
// which returns one signed 16-bit mixed sample on the rsp channel. Voice
// level and phase live in two small memories walked by a single per-voice
// datapath, one voice per cycle: after an item is accepted req_tready stays
// low while every voice is walked, and on a sample request also until the
// sample is loaded into the output register, so a new item is only taken
// once the last one is through. A finished sample sits in the output
// register, so the next item is taken while it waits; a sample that finishes
// while the one before it is still unread holds in its last step until
// rsp_tready takes the older one. After reset every voice reads as silent at
// once through per-voice valid bits; there is no clearing pass. Registers:
// index 0 peak_level (21 bits), index 1 decay_step (16 bits); the user must
// see that they are written only while idle; the block does not enforce it.
`default_nettype none

module square_wave_voice_mixer
   import swvm_pkg::*;
#(
   parameter int VOICES      = 20,
   parameter int SAMPLE_RATE = 44100
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // req: tdata = key_valid [0], key_index [5:1], zero pad [7:6]
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,
   // req: tuser = opcode [0]
   input  wire logic [0:0]           req_tuser,
   // rsp: tdata = sample_out [15:0]
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]       rsp_tdata,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [LEVEL_W-1:0]   csr_wdata
);

   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CMP_W = 7;
   localparam int MIX_W = SAMPLE_W + 2;

   function automatic logic [PHASE_W-1:0] phase_inc(input int key);
      int          n;
      logic [63:0] f;
      n = key + 3;
      f = 64'(SEMITONE_Q16[n % 12]) << (n / 12);
      phase_inc = PHASE_W'((f << 16) / 64'(SAMPLE_RATE));
   endfunction

   logic [PHASE_W-1:0] inc_table [VOICES];

   for (genvar g = 0; g < VOICES; g++) begin : g_inc
      localparam logic [PHASE_W-1:0] INC = phase_inc(g);
      assign inc_table[g] = INC;
   end

   state_type state_ff, state_in;

   logic [LEVEL_W-1:0]  peak_ff, peak_in;
   logic [DECAY_W-1:0]  decay_ff, decay_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [VOICES-1:0]   valid_ff, valid_in;
   logic                op_ff, op_in;
   logic                key_valid_ff, key_valid_in;
   logic [KEY_W-1:0]    key_index_ff, key_index_in;
   logic signed [SAMPLE_W-1:0] sum_ff, sum_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [SAMPLE_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [LEVEL_W-1:0]  rd_level_ff;
   logic [PHASE_W-1:0]  rd_phase_ff;

   logic [LEVEL_W-1:0]  level_mem [VOICES];
   logic [PHASE_W-1:0]  phase_mem [VOICES];

   logic                req_accept;
   logic                last_voice;
   logic                mem_we;
   logic                load_rsp;
   logic [IDX_W-1:0]    rd_addr;

   logic [LEVEL_W-1:0]  lvl;
   logic [PHASE_W-1:0]  ph;
   logic [LEVEL_W-1:0]  decay_ext;
   logic [LEVEL_W-1:0]  decayed;
   logic [LEVEL_W:0]    attack_sum;
   logic [LEVEL_W-1:0]  attack;
   logic                below_peak;
   logic                key_hit;
   logic signed [MIX_W-1:0] amp;
   logic signed [MIX_W-1:0] mix;
   logic signed [SAMPLE_W-1:0] mix_clamped;
   logic [LEVEL_W-1:0]  new_level;
   logic [PHASE_W-1:0]  new_phase;
   logic signed [SAMPLE_W-1:0] new_sum;

   assign req_accept = req_tvalid && req_tready;
   assign last_voice = (idx_ff == IDX_W'(VOICES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_voice) begin
               state_in = (op_ff == OP_SAMPLE) ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_RUN:  mem_we     = 1'b1;
         ST_OUT:  load_rsp   = !rsp_tvalid_ff || rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   // read one voice ahead of the one being updated
   always_comb begin
      if (state_ff == ST_RUN && !last_voice) begin
         rd_addr = idx_ff + IDX_W'(1);
      end else begin
         rd_addr = '0;
      end
   end

   // per-voice datapath
   always_comb begin
      lvl        = valid_ff[idx_ff] ? rd_level_ff : '0;
      ph         = valid_ff[idx_ff] ? rd_phase_ff : '0;
      decay_ext  = LEVEL_W'(decay_ff);
      decayed    = (lvl > decay_ext) ? (lvl - decay_ext) : '0;
      attack_sum = (LEVEL_W + 1)'(peak_ff) + (LEVEL_W + 1)'(decay_ff >> 1);
      attack     = attack_sum[LEVEL_W] ? LEVEL_MAX : attack_sum[LEVEL_W-1:0];
      below_peak = lvl < peak_ff;
      key_hit    = key_valid_ff && (CMP_W'(key_index_ff) == CMP_W'(idx_ff));
      amp        = MIX_W'(lvl[LEVEL_W-1:AMP_SHIFT]);
      if (!ph[PHASE_W-1]) begin
         mix = MIX_W'(sum_ff) + amp;
      end else begin
         mix = MIX_W'(sum_ff) - amp;
      end
      if (mix > MIX_W'(32767)) begin
         mix_clamped = 16'sh7fff;
      end else if (mix < -MIX_W'(32768)) begin
         mix_clamped = 16'sh8000;
      end else begin
         mix_clamped = mix[SAMPLE_W-1:0];
      end

      new_level = lvl;
      new_phase = ph;
      new_sum   = sum_ff;
      if (op_ff == OP_CONTROL) begin
         if (key_hit) begin
            if (below_peak) begin
               new_level = attack;
               new_phase = '0;
            end
         end else if (lvl != '0) begin
            new_level = decayed;
         end
      end else if (lvl != '0) begin
         new_sum   = mix_clamped;
         new_phase = ph + inc_table[idx_ff];
         if (below_peak) begin
            new_level = decayed;
         end
      end
   end

   always_comb begin
      peak_in  = peak_ff;
      decay_in = decay_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PEAK_LEVEL: peak_in  = csr_wdata;
            CSR_DECAY_STEP: decay_in = csr_wdata[DECAY_W-1:0];
            default: begin
               peak_in  = peak_ff;
               decay_in = decay_ff;
            end
         endcase
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      op_in        = op_ff;
      key_valid_in = key_valid_ff;
      key_index_in = key_index_ff;
      sum_in       = sum_ff;
      if (req_accept) begin
         idx_in       = '0;
         op_in        = req_tuser[0];
         key_valid_in = req_tdata[0];
         key_index_in = req_tdata[KEY_W:1];
         sum_in       = '0;
      end
      if (mem_we) begin
         idx_in           = last_voice ? '0 : idx_ff + IDX_W'(1);
         valid_in[idx_ff] = 1'b1;
         sum_in           = new_sum;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = sum_ff;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         peak_ff       <= PEAK_RESET;
         decay_ff      <= DECAY_RESET;
         idx_ff        <= '0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         peak_ff       <= peak_in;
         decay_ff      <= decay_in;
         idx_ff        <= idx_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_valid_ff <= key_valid_in;
      key_index_ff <= key_index_in;
      sum_ff       <= sum_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // voice memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         level_mem[idx_ff] <= new_level;
         phase_mem[idx_ff] <= new_phase;
      end
      rd_level_ff <= level_mem[rd_addr];
      rd_phase_ff <= phase_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/swvm_checker.sv -----
`default_nettype none

module swvm_checker
   import swvm_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tvalid,
   input wire logic                req_tready,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [SAMPLE_W-1:0] rsp_tdata
);

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // an accepted item keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted item");

   // a new result only shows up at the end of a busy period
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("rsp item appeared while the block was idle");

   // reset leaves no result pending
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

endmodule

bind square_wave_voice_mixer swvm_checker u_swvm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
   import swvm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VOICE_COUNT    = 20;
   localparam int SAMPLE_RATE_HZ = 44100;
   localparam int SAMPLE_HI      = 32767;
   localparam int SAMPLE_LO      = -32768;
   localparam int SETTLE_CYCLES  = 40;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic [0:0]           req_tuser  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_tdata;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [LEVEL_W-1:0]   csr_wdata  = '0;

   square_wave_voice_mixer #(
      .VOICES      (VOICE_COUNT),
      .SAMPLE_RATE (SAMPLE_RATE_HZ)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // voice model
   logic [LEVEL_W-1:0] peak_level_q;
   logic [DECAY_W-1:0] decay_step_q;
   logic [LEVEL_W-1:0] voice_level_q [VOICE_COUNT];
   logic [PHASE_W-1:0] voice_phase_q [VOICE_COUNT];
   logic [PHASE_W-1:0] phase_step    [VOICE_COUNT];

   logic [SAMPLE_W-1:0] pending_samples [$];
   int error_count = 0;

   // sender pacing
   int burst_left = 0;
   bit req_held   = 0;

   // receiver stall pattern, plus long hold requested by a test
   int hold_len  = 0;
   int hold_seq  = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int rx_mode   = 0;
   int rx_left   = 0;
   int rx_tick   = 0;

   function automatic void build_phase_steps();
      logic [63:0] freq_q16;
      int n;
      for (int k = 0; k < VOICE_COUNT; k++) begin
         n = k + 3;
         freq_q16 = 64'(SEMITONE_Q16[n % 12]) << (n / 12);
         phase_step[k] = PHASE_W'((freq_q16 << 16) / 64'(SAMPLE_RATE_HZ));
      end
   endfunction

   function automatic void clear_voices();
      peak_level_q = PEAK_RESET;
      decay_step_q = DECAY_RESET;
      for (int k = 0; k < VOICE_COUNT; k++) begin
         voice_level_q[k] = '0;
         voice_phase_q[k] = '0;
      end
   endfunction

   function automatic logic [LEVEL_W-1:0] decayed(logic [LEVEL_W-1:0] lvl);
      return (lvl > LEVEL_W'(decay_step_q)) ? lvl - LEVEL_W'(decay_step_q) : '0;
   endfunction

   function automatic void press_key(logic kv, logic [KEY_W-1:0] ki);
      int unsigned boosted;
      boosted = int'(peak_level_q) + int'(decay_step_q >> 1);
      for (int k = 0; k < VOICE_COUNT; k++) begin
         if (kv && int'(ki) == k) begin
            // a sustaining key is left alone
            if (voice_level_q[k] < peak_level_q) begin
               voice_phase_q[k] = '0;
               voice_level_q[k] = (boosted > LEVEL_MAX) ? LEVEL_MAX : LEVEL_W'(boosted);
            end
         end else if (voice_level_q[k] != '0) begin
            voice_level_q[k] = decayed(voice_level_q[k]);
         end
      end
   endfunction

   function automatic logic [SAMPLE_W-1:0] mix_sample();
      int acc;
      int amp;
      acc = 0;
      for (int k = 0; k < VOICE_COUNT; k++) begin
         if (voice_level_q[k] != '0) begin
            amp = int'(voice_level_q[k] >> AMP_SHIFT);
            if (!voice_phase_q[k][PHASE_W-1]) begin
               acc += amp;
            end else begin
               acc -= amp;
            end
            if (acc > SAMPLE_HI) begin
               acc = SAMPLE_HI;
            end else if (acc < SAMPLE_LO) begin
               acc = SAMPLE_LO;
            end
            voice_phase_q[k] += phase_step[k];
            if (voice_level_q[k] < peak_level_q) begin
               voice_level_q[k] = decayed(voice_level_q[k]);
            end
         end
      end
      return SAMPLE_W'(acc);
   endfunction

   task automatic send_item(logic op, logic kv, logic [KEY_W-1:0] ki);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, ki, kv};
      req_held = 1;
      do @(posedge clock); while (!req_tready);
      if (op == OP_SAMPLE) begin
         pending_samples.push_back(mix_sample());
      end else begin
         press_key(kv, ki);
      end
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         req_held = 0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic send_random_item(int sample_pct);
      logic op;
      logic kv;
      logic [KEY_W-1:0] ki;
      op = ($urandom_range(0, 99) < sample_pct) ? OP_SAMPLE : OP_CONTROL;
      if (op == OP_CONTROL && $urandom_range(0, 99) < 80) begin
         kv = 1'b1;
         ki = KEY_W'($urandom_range(0, VOICE_COUNT - 1));
      end else begin
         kv = 1'($urandom_range(0, 1));
         ki = KEY_W'($urandom_range(0, 31));
      end
      send_item(op, kv, ki);
   endtask

   // stop offering, let every sample come back and the last tick finish
   task automatic wait_for_quiet();
      if (req_held) begin
         req_tvalid <= 1'b0;
         req_held = 0;
      end
      do @(posedge clock); while (pending_samples.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [LEVEL_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_PEAK_LEVEL: peak_level_q = value;
         CSR_DECAY_STEP: decay_step_q = value[DECAY_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed_keys();
      send_item(OP_CONTROL, 1'b1, 5'd0);
      send_item(OP_SAMPLE,  1'b0, 5'd0);
      send_item(OP_CONTROL, 1'b1, 5'd19);
      send_item(OP_SAMPLE,  1'b0, 5'd0);
      // out of range keys and no key: everything decays
      send_item(OP_CONTROL, 1'b1, 5'd20);
      send_item(OP_CONTROL, 1'b1, 5'd31);
      send_item(OP_CONTROL, 1'b0, 5'd5);
      send_item(OP_SAMPLE,  1'b1, 5'd31);
      // second press while sustaining leaves the key alone
      send_item(OP_CONTROL, 1'b1, 5'd0);
      send_item(OP_CONTROL, 1'b1, 5'd0);
      send_item(OP_SAMPLE,  1'b0, 5'd0);
      // stack voices until the mix clamps
      for (int k = 1; k <= 7; k++) begin
         send_item(OP_CONTROL, 1'b1, KEY_W'(k));
      end
      send_item(OP_SAMPLE, 1'b0, 5'd0);
      send_item(OP_SAMPLE, 1'b1, 5'd12);
      send_item(OP_SAMPLE, 1'b0, 5'd0);
   endtask

   task automatic test_register_settings();
      logic [LEVEL_W-1:0] peak;
      logic [LEVEL_W-1:0] decay_word;
      int items;
      int pct;
      for (int s = 0; s < 7; s++) begin
         items = 110;
         case (s)
            0: begin
               // level overflow saturates
               peak = LEVEL_MAX; decay_word = LEVEL_MAX; pct = 55;
            end
            1: begin
               // zero peak: no key can start
               peak = '0; decay_word = '0; pct = 50; items = 40;
            end
            2: begin
               // upper write bits are dropped, decay becomes zero
               peak = 21'd2000; decay_word = 21'h1F0000; pct = 70; items = 100;
            end
            3: begin
               peak = 21'd1200000; decay_word = 21'd65535; pct = 85;
            end
            4: begin
               peak = 21'd600000; decay_word = 21'd3000; pct = 90;
            end
            default: begin
               peak = LEVEL_W'($urandom_range(0, LEVEL_MAX));
               decay_word = LEVEL_W'($urandom);
               pct = 80;
            end
         endcase
         wait_for_quiet();
         write_reg(CSR_PEAK_LEVEL, peak);
         write_reg(CSR_DECAY_STEP, decay_word);
         if (s == 2) begin
            write_reg(CSR_SPARE_2, LEVEL_W'($urandom));
            write_reg(CSR_SPARE_3, LEVEL_MAX);
         end
         for (int i = 0; i < items; i++) begin
            send_random_item(pct);
         end
      end
   endtask

   task automatic test_output_backpressure();
      wait_for_quiet();
      write_reg(CSR_PEAK_LEVEL, PEAK_RESET);
      write_reg(CSR_DECAY_STEP, LEVEL_W'(DECAY_RESET));
      hold_len = 400;
      hold_seq++;
      burst_left = 1000;
      send_item(OP_CONTROL, 1'b1, 5'd3);
      send_item(OP_CONTROL, 1'b1, 5'd9);
      for (int i = 0; i < 12; i++) begin
         send_item(OP_SAMPLE, 1'b0, 5'd0);
      end
      burst_left = 1;
      wait_for_quiet();
   endtask

   task automatic test_random_play();
      for (int i = 0; i < 300; i++) begin
         send_random_item(50);
      end
      // mostly samples so phases get past the half turn
      for (int i = 0; i < 300; i++) begin
         send_random_item(92);
      end
   endtask

   always @(posedge clock) begin
      rx_tick++;
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(32, 256);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 99) >= 30);
            2: rsp_tready <= ($urandom_range(0, 99) >= 80);
            default: rsp_tready <= rx_tick[2];
         endcase
      end
   end

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            $error("sample_out: unexpected item %0d", $signed(rsp_tdata));
            error_count++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_tdata !== want) begin
               $error("sample_out: expected %0d, got %0d", $signed(want), $signed(rsp_tdata));
               error_count++;
            end
         end
      end
   end

   initial begin
      build_phase_steps();
      clear_voices();
      burst_left = $urandom_range(1, 40);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_keys();
      test_register_settings();
      test_output_backpressure();
      test_random_play();
      wait_for_quiet();
      if (error_count == 0 && pending_samples.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

endmodule

`default_nettype wire
